### rtl/core/abps_pkg.sv
// ----------------------------------------------------------------------------
// abps_pkg
// shared types, codes and lookup functions of the alarm buzzer sequencer
// ----------------------------------------------------------------------------
package abps_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_PLAY       = 3'd1,
        OP_STOP       = 3'd2,
        OP_SET_VOLUME = 3'd3,
        OP_SET_LEVEL  = 3'd4
    } op_t;

    localparam logic [1:0] LVL_NONE   = 2'd0;
    localparam logic [1:0] LVL_LOW    = 2'd1;
    localparam logic [1:0] LVL_MEDIUM = 2'd2;
    localparam logic [1:0] LVL_HIGH   = 2'd3;

    localparam logic [2:0]  VOL_MIN       = 3'd1;
    localparam logic [2:0]  VOL_MAX       = 3'd5;
    localparam logic [2:0]  VOL_RESET     = 3'd1;
    localparam logic [11:0] DAC_RESET     = 12'd3850;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] level;
        logic [7:0] repeats;
        logic [7:0] vreq;
    } cmd_t;

    typedef struct packed {
        logic        gate;
        logic [11:0] dac;
        logic        playing;
        logic [1:0]  level;
    } res_t;

    // on phase length in ticks
    function automatic logic [11:0] on_len(input logic [1:0] lvl);
        logic [11:0] len;
        case (lvl)
            LVL_LOW:    len = 12'd2200;
            LVL_MEDIUM: len = 12'd90;
            LVL_HIGH:   len = 12'd45;
            default:    len = 12'd0;
        endcase
        return len;
    endfunction

    // off phase length in ticks
    function automatic logic [11:0] off_len(input logic [1:0] lvl);
        logic [11:0] len;
        case (lvl)
            LVL_LOW:    len = 12'd100;
            LVL_MEDIUM: len = 12'd90;
            LVL_HIGH:   len = 12'd45;
            default:    len = 12'd0;
        endcase
        return len;
    endfunction

    // rounds when play gives none, 0 means forever
    function automatic logic [7:0] default_rounds(input logic [1:0] lvl);
        logic [7:0] r;
        case (lvl)
            LVL_LOW:    r = 8'd1;
            LVL_MEDIUM: r = 8'd15;
            default:    r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] min_vol(input logic [1:0] lvl);
        logic [2:0] m;
        case (lvl)
            LVL_LOW:    m = 3'd2;
            LVL_MEDIUM: m = 3'd3;
            LVL_HIGH:   m = 3'd5;
            default:    m = 3'd0;
        endcase
        return m;
    endfunction

    // dac code for a user volume at a level, higher code is quieter
    function automatic logic [11:0] vol_code(input logic [2:0] uv, input logic [1:0] lvl);
        logic [2:0]  v;
        logic [11:0] code;
        v = uv;
        if (v < min_vol(lvl)) v = min_vol(lvl);
        if (v > VOL_MAX) v = VOL_MAX;
        if (v < VOL_MIN) v = VOL_MIN;
        case (v)
            3'd2:    code = 12'd3450;
            3'd3:    code = 12'd2690;
            3'd4:    code = 12'd1900;
            3'd5:    code = 12'd500;
            default: code = 12'd3850;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/abps_engine.sv
// ----------------------------------------------------------------------------
// abps_engine
// sequencer state and its combinational update for one item
// ----------------------------------------------------------------------------
module abps_engine
    import abps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  cmd_t cmd,
    output res_t res
);

    logic [1:0]  level_reg,   level_next;
    logic [2:0]  uvol_reg,    uvol_next;
    logic        phase_reg,   phase_next;
    logic [11:0] elapsed_reg, elapsed_next;
    logic [7:0]  rounds_reg,  rounds_next;
    logic [11:0] dac_reg,     dac_next;
    logic        gate_reg,    gate_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= LVL_NONE;
            uvol_reg    <= VOL_RESET;
            phase_reg   <= 1'b0;
            elapsed_reg <= '0;
            rounds_reg  <= '0;
            dac_reg     <= DAC_RESET;
            gate_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            level_reg   <= level_next;
            uvol_reg    <= uvol_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            rounds_reg  <= rounds_next;
            dac_reg     <= dac_next;
            gate_reg    <= gate_next;
        end
    end

    always_comb
    begin
        logic        stop_en;
        logic        play_en;
        logic [1:0]  play_lvl;
        logic [7:0]  play_reps;
        logic [11:0] limit;
        logic [11:0] elapsed_inc;
        logic [7:0]  rounds_dec;

        level_next   = level_reg;
        uvol_next    = uvol_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        rounds_next  = rounds_reg;
        dac_next     = dac_reg;
        gate_next    = gate_reg;
        stop_en      = 1'b0;
        play_en      = 1'b0;
        play_lvl     = cmd.level;
        play_reps    = cmd.repeats;
        limit        = phase_reg ? off_len(level_reg) : on_len(level_reg);
        elapsed_inc  = elapsed_reg + 12'd1;
        rounds_dec   = rounds_reg - 8'd1;

        case (op_t'(cmd.op))
            OP_TICK:
            begin
                if (level_reg != LVL_NONE)
                begin
                    if (elapsed_inc < limit)
                    begin
                        elapsed_next = elapsed_inc;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        if (!phase_reg)
                        begin
                            phase_next = 1'b1;
                            gate_next  = 1'b0;
                        end
                        else
                        begin
                            phase_next = 1'b0;
                            gate_next  = 1'b1;
                            if (rounds_reg != 8'd0)
                            begin
                                rounds_next = rounds_dec;
                                if (rounds_dec == 8'd0)
                                    stop_en = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_PLAY:
            begin
                if (cmd.level == LVL_NONE)
                    stop_en = 1'b1;
                else
                    play_en = 1'b1;
            end
            OP_STOP:
            begin
                stop_en = 1'b1;
            end
            OP_SET_VOLUME:
            begin
                uvol_next = (cmd.vreq > 8'(VOL_MAX)) ? VOL_MAX : cmd.vreq[2:0];
                if (level_reg != LVL_NONE)
                    dac_next = vol_code(uvol_next, level_reg);
            end
            OP_SET_LEVEL:
            begin
                if (cmd.level != level_reg)
                begin
                    if (cmd.level == LVL_NONE)
                        stop_en = 1'b1;
                    else
                    begin
                        play_en   = 1'b1;
                        play_reps = 8'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (stop_en)
        begin
            level_next  = LVL_NONE;
            rounds_next = '0;
            gate_next   = 1'b0;
        end
        if (play_en)
        begin
            level_next   = play_lvl;
            phase_next   = 1'b0;
            elapsed_next = '0;
            rounds_next  = (play_reps != 8'd0) ? play_reps : default_rounds(play_lvl);
            dac_next     = vol_code(uvol_reg, play_lvl);
            gate_next    = 1'b1;
        end

        res.gate    = gate_next;
        res.dac     = dac_next;
        res.playing = (level_next != LVL_NONE);
        res.level   = level_next;
    end

    // the gate only sounds while a level is active
    a_gate_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        gate_reg |-> level_reg != LVL_NONE)
        else $error("gate on with no active level");

    // idle means no rounds pending
    a_idle_no_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg == LVL_NONE |-> rounds_reg == 8'd0)
        else $error("rounds left while idle");

    a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        uvol_reg <= VOL_MAX)
        else $error("user volume out of range");

    // stop always leaves the sequencer idle
    a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && cmd.op == OP_STOP |=> level_reg == LVL_NONE && !gate_reg)
        else $error("stop did not silence the buzzer");

endmodule

### rtl/core/alarm_buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// alarm_buzzer_pattern_sequencer
// buzzer on/off pattern and level dac code driven by 1 ms tick items
// ----------------------------------------------------------------------------
// an accepted item is held in the input register, then its result is registered in the result register
// throughput: one item per cycle while the result channel does not stall, set by the state update
// the input register refills while a finished result waits in the result register
// reset: asynchronous, idle with level none, volume 1, dac code 3850, gate off
// ----------------------------------------------------------------------------
module alarm_buzzer_pattern_sequencer
    import abps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  operation,
    input  logic [1:0]  alarm_level,
    input  logic [7:0]  repeat_count,
    input  logic [7:0]  volume_request,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic        gate_on,
    output logic [11:0] dac_code,
    output logic        playing,
    output logic [1:0]  level_now
);

    // input register
    logic cmd_valid_reg;
    cmd_t cmd_reg;

    // result register
    logic res_valid_reg;
    res_t res_reg;

    res_t res_next;
    logic res_free;
    logic step_en;

    // the result register can take a new item when empty or being drained
    assign res_free  = !res_valid_reg || !res_stall;
    // the held item is processed and its state committed in the same cycle
    assign step_en   = cmd_valid_reg && res_free;
    // only a held item that cannot move on blocks the input
    assign cmd_stall = cmd_valid_reg && !res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (cmd_valid && !cmd_stall)
            cmd_valid_reg <= 1'b1;
        else if (step_en)
            cmd_valid_reg <= 1'b0;
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg.op      <= operation;
            cmd_reg.level   <= alarm_level;
            cmd_reg.repeats <= repeat_count;
            cmd_reg.vreq    <= volume_request;
        end
    end

    // pattern state and update logic
    abps_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .cmd     (cmd_reg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step_en)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    // the result holds while stalled
    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign gate_on   = res_reg.gate;
    assign dac_code  = res_reg.dac;
    assign playing   = res_reg.playing;
    assign level_now = res_reg.level;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the alarm buzzer pattern sequencer: a queue of
// directed and random items feeds the command channel, a model of the
// sequencer predicts every result and the result channel is checked in order
// ----------------------------------------------------------------------------
module testbench;
    import abps_pkg::*;

    // spare operation codes, the block must leave its state alone
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int TOTAL_ITEMS   = 950;
    localparam int MAX_WAIT      = 19;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        cmd_t        cmd;
        int unsigned gap;
    } queued_item_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cmd_valid      = 1'b0;
    logic        cmd_stall;
    logic [2:0]  operation      = '0;
    logic [1:0]  alarm_level    = '0;
    logic [7:0]  repeat_count   = '0;
    logic [7:0]  volume_request = '0;
    logic        res_valid;
    logic        res_stall      = 1'b1;
    logic        gate_on;
    logic [11:0] dac_code;
    logic        playing;
    logic [1:0]  level_now;

    always #5 clk = ~clk;

    alarm_buzzer_pattern_sequencer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .operation      (operation),
        .alarm_level    (alarm_level),
        .repeat_count   (repeat_count),
        .volume_request (volume_request),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .gate_on        (gate_on),
        .dac_code       (dac_code),
        .playing        (playing),
        .level_now      (level_now)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    queued_item_t pending_items[$];
    res_t         expected_outputs[$];

    bit          cmd_taken;           // command item moved at the last rising edge
    bit          res_taken;           // result item moved at the last rising edge
    bit          sender_busy;         // filler side: items go out back to back
    bit          receiver_busy = 1'b0;
    int unsigned send_gap_left = 0;
    int unsigned stall_left    = 0;
    int unsigned items_total    = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned error_count    = 0;
    int unsigned ops_seen [0:7];
    int unsigned rounds_expired = 0;
    int unsigned gate_changes   = 0;

    // sequencer model state, reset values as after the block's reset
    logic [1:0]  pred_level     = LVL_NONE;
    logic [2:0]  pred_volume    = VOL_RESET;
    logic        pred_phase_off = 1'b0;
    logic [11:0] pred_elapsed   = '0;
    logic [7:0]  pred_rounds    = '0;
    logic [11:0] pred_dac       = DAC_RESET;
    logic        pred_gate      = 1'b0;

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------
    function automatic logic [11:0] on_ticks(input logic [1:0] lvl);
        case (lvl)
            LVL_LOW:    return 12'd2200;
            LVL_MEDIUM: return 12'd90;
            LVL_HIGH:   return 12'd45;
            default:    return 12'd0;
        endcase
    endfunction

    function automatic logic [11:0] off_ticks(input logic [1:0] lvl);
        case (lvl)
            LVL_LOW:    return 12'd100;
            LVL_MEDIUM: return 12'd90;
            LVL_HIGH:   return 12'd45;
            default:    return 12'd0;
        endcase
    endfunction

    // dac code: user volume lifted to the level's floor, then held to 1..5
    function automatic logic [11:0] dac_for(input logic [1:0] lvl, input logic [2:0] uv);
        logic [2:0] floor_vol;
        logic [2:0] v;
        case (lvl)
            LVL_LOW:    floor_vol = 3'd2;
            LVL_MEDIUM: floor_vol = 3'd3;
            LVL_HIGH:   floor_vol = 3'd5;
            default:    floor_vol = 3'd0;
        endcase
        v = (uv < floor_vol) ? floor_vol : uv;
        if (v > VOL_MAX) v = VOL_MAX;
        if (v < VOL_MIN) v = VOL_MIN;
        case (v)
            3'd2:    return 12'd3450;
            3'd3:    return 12'd2690;
            3'd4:    return 12'd1900;
            3'd5:    return 12'd500;
            default: return 12'd3850;
        endcase
    endfunction

    // phase position and dac code are kept over a stop
    function automatic void silence();
        pred_level  = LVL_NONE;
        pred_rounds = '0;
        pred_gate   = 1'b0;
    endfunction

    function automatic void start_pattern(input logic [1:0] lvl, input logic [7:0] reps);
        if (lvl == LVL_NONE) begin
            silence();
        end
        else begin
            pred_level     = lvl;
            pred_phase_off = 1'b0;
            pred_elapsed   = '0;
            if (reps != 8'd0)
                pred_rounds = reps;
            else if (lvl == LVL_LOW)
                pred_rounds = 8'd1;
            else if (lvl == LVL_MEDIUM)
                pred_rounds = 8'd15;
            else
                pred_rounds = 8'd0;     // high plays until stopped
            pred_dac  = dac_for(lvl, pred_volume);
            pred_gate = 1'b1;
        end
    endfunction

    function automatic void advance_pattern();
        logic [11:0] limit;
        if (pred_level != LVL_NONE) begin
            limit = pred_phase_off ? off_ticks(pred_level) : on_ticks(pred_level);
            pred_elapsed = pred_elapsed + 12'd1;
            if (pred_elapsed >= limit) begin
                pred_elapsed = '0;
                if (!pred_phase_off) begin
                    pred_phase_off = 1'b1;
                    pred_gate      = 1'b0;
                end
                else begin
                    // one on+off pair done
                    pred_phase_off = 1'b0;
                    if (pred_rounds == 8'd1) begin
                        silence();
                        rounds_expired++;
                    end
                    else begin
                        if (pred_rounds != 8'd0)
                            pred_rounds = pred_rounds - 8'd1;
                        pred_gate = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic res_t buzzer_predict(input cmd_t c);
        res_t r;
        logic gate_was;
        gate_was = pred_gate;
        ops_seen[c.op]++;
        case (c.op)
            OP_TICK: advance_pattern();
            OP_PLAY: start_pattern(c.level, c.repeats);
            OP_STOP: silence();
            OP_SET_VOLUME:
            begin
                pred_volume = (c.vreq > 8'(VOL_MAX)) ? VOL_MAX : c.vreq[2:0];
                if (pred_level != LVL_NONE)
                    pred_dac = dac_for(pred_level, pred_volume);
            end
            OP_SET_LEVEL:
            begin
                if (c.level != pred_level)
                    start_pattern(c.level, 8'd0);
            end
            default: ;      // spare codes
        endcase
        if (pred_gate != gate_was)
            gate_changes++;
        r.gate    = pred_gate;
        r.dac     = pred_dac;
        r.playing = (pred_level != LVL_NONE);
        r.level   = pred_level;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus queue helpers
    // ------------------------------------------------------------------------
    task automatic add_item(input logic [2:0] op, input logic [1:0] lvl,
                            input logic [7:0] reps, input logic [7:0] vreq);
        queued_item_t q;
        q.cmd.op      = op;
        q.cmd.level   = lvl;
        q.cmd.repeats = reps;
        q.cmd.vreq    = vreq;
        q.gap         = sender_busy ? 0 : $urandom_range(0, MAX_WAIT);
        pending_items.push_back(q);
        items_total++;
    endtask

    // random fields, biased towards small repeat counts and volumes near the clamp
    task automatic add_random(input logic [2:0] op);
        logic [7:0] reps;
        logic [7:0] vreq;
        reps = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 3));
        vreq = $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                    : 8'($urandom_range(0, 255));
        add_item(op, 2'($urandom_range(0, 3)), reps, vreq);
    endtask

    // ------------------------------------------------------------------------
    // command driver: items from the queue, payload held while stalled
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_commands
        queued_item_t nxt;
        if (rst_n && !(cmd_valid && !cmd_taken)) begin
            if (send_gap_left != 0) begin
                cmd_valid <= 1'b0;
                send_gap_left--;
            end
            else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                cmd_valid      <= 1'b1;
                operation      <= nxt.cmd.op;
                alarm_level    <= nxt.cmd.level;
                repeat_count   <= nxt.cmd.repeats;
                volume_request <= nxt.cmd.vreq;
                send_gap_left  = nxt.gap;
            end
            else begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stall per result, with stretches of none
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_stall
        if (res_taken) begin
            if (results_checked % 128 == 0)
                receiver_busy = ($urandom_range(0, 3) == 0);
            stall_left = receiver_busy ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (rst_n) begin
            res_stall <= (stall_left != 0);
            // count the stall down only while a result is waiting
            if (stall_left != 0 && res_valid)
                stall_left--;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check the result that moved, then predict the item that moved
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch_channels
        cmd_t seen_cmd;
        res_t want;
        cmd_taken = rst_n && cmd_valid && !cmd_stall;
        res_taken = rst_n && res_valid && !res_stall;
        if (res_taken) begin
            results_checked++;
            if (expected_outputs.size() == 0) begin
                $display("%0t ns: result with none expected: gate %0d dac %0d playing %0d level %0d",
                         $time, gate_on, dac_code, playing, level_now);
                error_count++;
            end
            else begin
                want = expected_outputs.pop_front();
                compare_field("gate_on", 12'(want.gate), 12'(gate_on));
                compare_field("dac_code", want.dac, dac_code);
                compare_field("playing", 12'(want.playing), 12'(playing));
                compare_field("level_now", 12'(want.level), 12'(level_now));
            end
        end
        if (cmd_taken) begin
            seen_cmd.op      = operation;
            seen_cmd.level   = alarm_level;
            seen_cmd.repeats = repeat_count;
            seen_cmd.vreq    = volume_request;
            expected_outputs.push_back(buzzer_predict(seen_cmd));
            items_accepted++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : run_sequence
        int unsigned burst;
        logic [1:0]  lvl;
        logic [7:0]  reps;
        int          pick;

        foreach (ops_seen[i])
            ops_seen[i] = 0;

        // directed opening, each item sent with random idling
        sender_busy = 1'b0;
        add_item(OP_TICK, LVL_HIGH, 8'hFF, 8'hFF);           // tick while idle
        for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
            add_random(3'(code));                             // spare codes do nothing
        add_item(OP_SET_VOLUME, LVL_NONE, 8'h00, 8'd0);      // idle: volume set to 0, dac untouched
        add_item(OP_PLAY, LVL_LOW, 8'd0, 8'hFF);             // default single round, floor 2
        add_item(OP_SET_VOLUME, LVL_LOW, 8'hFF, 8'hFF);      // clamped to 5
        add_item(OP_SET_VOLUME, LVL_LOW, 8'h00, 8'd6);       // just over the clamp
        add_item(OP_SET_VOLUME, LVL_LOW, 8'h00, 8'd4);
        add_item(OP_SET_LEVEL, LVL_LOW, 8'hFF, 8'h00);       // same level, no change
        add_item(OP_TICK, LVL_NONE, 8'h00, 8'h00);
        add_item(OP_SET_LEVEL, LVL_HIGH, 8'h00, 8'h00);      // new level plays forever
        add_item(OP_TICK, LVL_HIGH, 8'hFF, 8'hFF);
        add_item(OP_SET_VOLUME, LVL_HIGH, 8'h00, 8'd1);      // lifted to the high floor
        add_item(OP_SET_LEVEL, LVL_NONE, 8'h00, 8'h00);      // level none acts as stop
        add_item(OP_SET_LEVEL, LVL_NONE, 8'hFF, 8'hFF);      // already none
        add_item(OP_PLAY, LVL_MEDIUM, 8'hFF, 8'h00);         // widest repeat count
        add_item(OP_SET_VOLUME, LVL_MEDIUM, 8'h00, 8'd2);    // lifted to the medium floor
        add_item(OP_PLAY, LVL_NONE, 8'd3, 8'hFF);            // play with none stops
        add_item(OP_STOP, LVL_HIGH, 8'hFF, 8'hFF);           // stop while idle
        add_item(OP_PLAY, LVL_HIGH, 8'd1, 8'h00);
        add_item(OP_STOP, LVL_NONE, 8'h00, 8'h00);           // stop keeps the dac code

        // random part: mostly a start followed by a run of ticks, the rest noise
        while (items_total < TOTAL_ITEMS) begin
            sender_busy = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                case ($urandom_range(0, 4))
                    0:       lvl = LVL_LOW;
                    1, 2:    lvl = LVL_MEDIUM;
                    default: lvl = LVL_HIGH;
                endcase
                reps = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 2));
                if ($urandom_range(0, 2) != 0)
                    add_item(OP_PLAY, lvl, reps, 8'($urandom_range(0, 255)));
                else
                    add_item(OP_SET_LEVEL, lvl, reps, 8'($urandom_range(0, 255)));
                // long enough runs to cross phases and use up short round counts
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(90, 200)
                                                    : $urandom_range(1, 50);
                for (int i = 0; i < burst && items_total < TOTAL_ITEMS; i++) begin
                    case ($urandom_range(0, 39))
                        0:       add_random(OP_SET_VOLUME);
                        1:       add_random(OP_SET_LEVEL);
                        default: add_random(OP_TICK);
                    endcase
                end
            end
            else if (pick == 7) begin
                add_random(3'($urandom_range(0, OP_SPARE_LAST)));
            end
            else if (pick == 8) begin
                add_random(OP_STOP);
                repeat ($urandom_range(0, 4))
                    add_random(OP_TICK);
            end
            else begin
                add_random(OP_SET_VOLUME);
            end
        end

        // reset once, released away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every item taken and every result back, then let the block settle
        while (items_accepted != items_total || expected_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (expected_outputs.size() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, expected_outputs.size());
            error_count++;
        end

        $display("items: %0d ticks, %0d plays, %0d stops, %0d volume, %0d level, %0d spare",
                 ops_seen[OP_TICK], ops_seen[OP_PLAY], ops_seen[OP_STOP],
                 ops_seen[OP_SET_VOLUME], ops_seen[OP_SET_LEVEL],
                 ops_seen[5] + ops_seen[6] + ops_seen[7]);
        $display("results: %0d checked, %0d gate changes, %0d patterns ran out of rounds",
                 results_checked, gate_changes, rounds_expired);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin : watchdog
        #10_000_000;
        $display("%0t ns: run did not finish", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/core/abps_pkg.sv
rtl/core/abps_engine.sv
rtl/core/alarm_buzzer_pattern_sequencer.sv
tb/testbench.sv
